>>> hw/rtl/rpnf_pkg.sv
// Shared types and constants for the RC pulse normalizer with failsafe.
// Used by the configuration bank, the serial divider and the top level.
`default_nettype none

package rpnf_pkg;

    localparam int PW_W    = 12;  // pulse width field, microseconds
    localparam int DB_W    = 10;  // deadband half width
    localparam int TMO_W   = 24;  // timeout limit
    localparam int DT_W    = 16;  // elapsed time per tick
    localparam int SIL_W   = 25;  // silence timer
    localparam int NORM_W  = 16;  // Q1.14 output
    localparam int Q_FRAC  = 14;  // fraction bits of the command
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [Q_FRAC:0]      Q_ONE         = 15'd16384;
    localparam logic [Q_FRAC:0]      SAFE_LIMIT    = 15'd819;
    localparam logic [PW_W+1:0]      ACCEPT_MARGIN = 14'd200;
    localparam logic [SIL_W-1:0]     SILENCE_MAX   = {SIL_W{1'b1}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_CENTER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFE_START   = 3'd5;

    // Register reset values
    localparam logic [PW_W-1:0]  RST_PULSE_MIN    = 12'd1000;
    localparam logic [PW_W-1:0]  RST_PULSE_MAX    = 12'd2000;
    localparam logic [PW_W-1:0]  RST_PULSE_CENTER = 12'd1500;
    localparam logic [DB_W-1:0]  RST_DEADBAND     = 10'd50;
    localparam logic [TMO_W-1:0] RST_TIMEOUT      = 24'd200000;

    typedef struct packed {
        logic [PW_W-1:0]  pulse_min;
        logic [PW_W-1:0]  pulse_max;
        logic [PW_W-1:0]  pulse_center;
        logic [DB_W-1:0]  deadband;
        logic [TMO_W-1:0] timeout_limit;
        logic             safe_start_enable;
    } t_cfg;

endpackage

`default_nettype wire

>>> hw/rtl/rpnf_cfg.sv
// Configuration register bank for the RC pulse normalizer.
// Depends on rpnf_pkg for register indexes, reset values and t_cfg.
`default_nettype none

module rpnf_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr,
    input  wire logic [rpnf_pkg::CFG_IDX_W-1:0]  i_idx,
    input  wire logic [rpnf_pkg::CFG_DATA_W-1:0] i_data,
    output rpnf_pkg::t_cfg                      o_cfg
);

    rpnf_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_min         <= rpnf_pkg::RST_PULSE_MIN;
            r_cfg.pulse_max         <= rpnf_pkg::RST_PULSE_MAX;
            r_cfg.pulse_center      <= rpnf_pkg::RST_PULSE_CENTER;
            r_cfg.deadband          <= rpnf_pkg::RST_DEADBAND;
            r_cfg.timeout_limit     <= rpnf_pkg::RST_TIMEOUT;
            r_cfg.safe_start_enable <= 1'b0;
        end else if (i_wr) begin
            unique case (i_idx)
                rpnf_pkg::CFG_PULSE_MIN:    r_cfg.pulse_min    <= i_data[rpnf_pkg::PW_W-1:0];
                rpnf_pkg::CFG_PULSE_MAX:    r_cfg.pulse_max    <= i_data[rpnf_pkg::PW_W-1:0];
                rpnf_pkg::CFG_PULSE_CENTER: r_cfg.pulse_center <= i_data[rpnf_pkg::PW_W-1:0];
                rpnf_pkg::CFG_DEADBAND:     r_cfg.deadband     <= i_data[rpnf_pkg::DB_W-1:0];
                rpnf_pkg::CFG_TIMEOUT:      r_cfg.timeout_limit <= i_data[rpnf_pkg::TMO_W-1:0];
                rpnf_pkg::CFG_SAFE_START:   r_cfg.safe_start_enable <= i_data[0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> hw/rtl/rpnf_div.sv
// Restoring serial divider, one quotient bit per cycle, Q_FRAC bits.
// Expects numerator below divisor; quotient is num * 2^Q_FRAC / den.
// Depends on rpnf_pkg for widths.
`default_nettype none

module rpnf_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [rpnf_pkg::PW_W-1:0]   i_num,
    input  wire logic [rpnf_pkg::PW_W-1:0]   i_den,
    output logic                             o_done,
    output logic [rpnf_pkg::Q_FRAC-1:0]      o_quo
);

    localparam int CNT_W = $clog2(rpnf_pkg::Q_FRAC);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(rpnf_pkg::Q_FRAC - 1);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [rpnf_pkg::PW_W-1:0]     r_rem;
    logic [rpnf_pkg::PW_W-1:0]     r_den;
    logic [rpnf_pkg::Q_FRAC-1:0]   r_quo;

    logic [rpnf_pkg::PW_W:0]       w_sh;
    logic [rpnf_pkg::PW_W:0]       w_sub;
    logic                          w_ge;

    assign w_sh  = {r_rem, 1'b0};
    assign w_ge  = w_sh >= {1'b0, r_den};
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits PW_W bits
            r_rem <= w_ge ? w_sub[rpnf_pkg::PW_W-1:0] : w_sh[rpnf_pkg::PW_W-1:0];
            r_quo <= {r_quo[rpnf_pkg::Q_FRAC-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

>>> hw/rtl/rc_pulse_normalizer_failsafe.sv
// RC pulse normalizer with deadband and failsafe: top level and sequencer.
// Depends on rpnf_pkg, rpnf_cfg and rpnf_div.
//
// One tick in, one result out. A tick is accepted only while the block is
// idle; with no division needed (signal lost, pulse inside the deadband,
// empty span or full-scale clamp) it goes from scaling straight to finish,
// else the 14-step serial divider computes the Q1.14 command. The finished
// result may wait for a free output register. The result register sits
// between the two sides, so a stalled result does not block the next tick's
// work until it is done. Configuration writes are always ready and take
// effect at once; write them only between ticks.
`default_nettype none

module rc_pulse_normalizer_failsafe (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [rpnf_pkg::PW_W-1:0]       i_pulse_width,
    input  wire logic                            i_read_ok,
    input  wire logic                            i_signal_present,
    input  wire logic [rpnf_pkg::DT_W-1:0]       i_elapsed_us,
    // output channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic signed [rpnf_pkg::NORM_W-1:0]   o_norm_out,
    output logic                                 o_lost_flag,
    output logic                                 o_safe_flag,
    output logic [rpnf_pkg::PW_W-1:0]            o_latched_pulse,
    // configuration channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rpnf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rpnf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PW  = rpnf_pkg::PW_W;
    localparam int QF  = rpnf_pkg::Q_FRAC;
    localparam int SIL = rpnf_pkg::SIL_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_SCALE  = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    rpnf_pkg::t_cfg cfg;
    logic           w_cfg_wr;

    logic [2:0]     r_state, n_state;

    // captured tick
    logic [PW-1:0]              r_pw;
    logic                       r_ok;
    logic [rpnf_pkg::DT_W-1:0]  r_dt;

    // persistent state
    logic [PW-1:0]   r_held_pulse;
    logic [SIL-1:0]  r_silence;
    logic            r_lost;
    logic            r_unlocked;

    // per-tick work
    logic            r_held;
    logic            r_neg;
    logic [QF:0]     r_qmag;

    // result register
    logic                               r_out_valid;
    logic signed [rpnf_pkg::NORM_W-1:0] r_norm;
    logic                               r_lost_out;
    logic                               r_safe_out;
    logic [PW-1:0]                      r_latched;

    // divider
    logic            w_div_start;
    logic            w_div_done;
    logic [QF-1:0]   w_div_quo;

    // evaluation
    logic            w_in_range;
    logic [SIL:0]    w_sum;
    logic [SIL-1:0]  w_sil_sat;
    logic            w_timeout;

    // scaling
    logic [PW:0]            w_hi;
    logic signed [PW+1:0]   w_hi_s, w_lo_s, w_p_s;
    logic signed [PW+1:0]   w_diff_hi, w_span_hi, w_diff_lo, w_span_lo;
    logic signed [PW+1:0]   w_num_s, w_span_s;
    logic                   w_side_hi, w_side_lo, w_go, w_clamp;

    // finish
    logic                               w_out_free;
    logic                               w_small;
    logic signed [rpnf_pkg::NORM_W-1:0] w_q;

    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;

    rpnf_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (w_cfg_wr),
        .i_idx  (i_cfg_index),
        .i_data (i_cfg_data),
        .o_cfg  (cfg)
    );

    rpnf_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_num_s[PW-1:0]),
        .i_den  (w_span_s[PW-1:0]),
        .o_done (w_div_done),
        .o_quo  (w_div_quo)
    );

    // ---- evaluation: window check and silence timer ----
    assign w_in_range = r_ok &&
        ({2'b00, r_pw} + rpnf_pkg::ACCEPT_MARGIN >= {2'b00, cfg.pulse_min}) &&
        ({2'b00, r_pw} <= {2'b00, cfg.pulse_max} + rpnf_pkg::ACCEPT_MARGIN);
    assign w_sum     = {1'b0, r_silence} + {{(SIL + 1 - rpnf_pkg::DT_W){1'b0}}, r_dt};
    assign w_sil_sat = w_sum[SIL] ? rpnf_pkg::SILENCE_MAX : w_sum[SIL-1:0];
    assign w_timeout = w_sil_sat > {{(SIL - rpnf_pkg::TMO_W){1'b0}}, cfg.timeout_limit};

    // ---- scaling: pick side, numerator and span ----
    assign w_hi      = {1'b0, cfg.pulse_center} + {{(PW + 1 - rpnf_pkg::DB_W){1'b0}}, cfg.deadband};
    assign w_hi_s    = $signed({1'b0, w_hi});
    assign w_lo_s    = $signed({2'b00, cfg.pulse_center})
                     - $signed({{(PW + 2 - rpnf_pkg::DB_W){1'b0}}, cfg.deadband});
    assign w_p_s     = $signed({2'b00, r_held_pulse});
    assign w_diff_hi = w_p_s - w_hi_s;
    assign w_span_hi = $signed({2'b00, cfg.pulse_max}) - w_hi_s;
    assign w_diff_lo = w_lo_s - w_p_s;
    assign w_span_lo = w_lo_s - $signed({2'b00, cfg.pulse_min});
    assign w_side_hi = w_diff_hi > 0;
    assign w_side_lo = w_diff_lo > 0;
    assign w_num_s   = w_side_lo ? w_diff_lo : w_diff_hi;
    assign w_span_s  = w_side_lo ? w_span_lo : w_span_hi;
    assign w_go      = r_held && (w_side_hi || w_side_lo) && (w_span_s > 0);
    // numerator at or above the span means a quotient of full scale or more
    assign w_clamp   = w_num_s >= w_span_s;
    assign w_div_start = (r_state == S_SCALE) && w_go && !w_clamp;

    // ---- finish: sign, safe start ----
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_small    = r_qmag < rpnf_pkg::SAFE_LIMIT;
    assign w_q        = r_neg ? -$signed({1'b0, r_qmag}) : $signed({1'b0, r_qmag});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_EVAL;
            S_EVAL:   n_state = S_SCALE;
            S_SCALE:  n_state = w_div_start ? S_DIV : S_FINISH;
            S_DIV:    if (w_div_done) n_state = S_FINISH;
            S_FINISH: if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_held_pulse <= '0;
            r_silence    <= '0;
            r_lost       <= 1'b1;
            r_unlocked   <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == S_EVAL) begin
                if (w_in_range) begin
                    r_held_pulse <= r_pw;
                    r_silence    <= '0;
                    r_lost       <= 1'b0;
                end else begin
                    r_silence <= w_sil_sat;
                    if (w_timeout) r_lost <= 1'b1;
                end
            end

            if (w_cfg_wr && i_cfg_index == rpnf_pkg::CFG_SAFE_START) begin
                r_unlocked <= !i_cfg_data[0];
            end else if (r_state == S_FINISH && w_out_free && r_held && w_small) begin
                r_unlocked <= 1'b1;
            end

            if (r_state == S_FINISH && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_pw <= i_pulse_width;
            r_ok <= i_read_ok && i_signal_present;
            r_dt <= i_elapsed_us;
        end

        if (r_state == S_EVAL) begin
            r_held <= w_in_range || (!w_timeout && !r_lost);
        end

        if (r_state == S_SCALE) begin
            r_neg <= w_side_lo;
            if (!w_go) begin
                r_qmag <= '0;
            end else if (w_clamp) begin
                r_qmag <= rpnf_pkg::Q_ONE;
            end
        end else if (r_state == S_DIV && w_div_done) begin
            r_qmag <= {1'b0, w_div_quo};
        end

        if (r_state == S_FINISH && w_out_free) begin
            // hold the command at zero until safe start sees near neutral
            r_norm     <= (r_unlocked || w_small) ? w_q : '0;
            r_lost_out <= r_lost;
            r_safe_out <= !r_lost && (r_unlocked || (r_held && w_small));
            r_latched  <= r_held_pulse;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_norm_out      = r_norm;
    assign o_lost_flag     = r_lost_out;
    assign o_safe_flag     = r_safe_out;
    assign o_latched_pulse = r_latched;

endmodule

`default_nettype wire

>>> hw/rtl/rpnf_checker.sv
// Port-level checker for rc_pulse_normalizer_failsafe, attached by bind.
// Depends on rpnf_pkg for widths.
`default_nettype none

module rpnf_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic signed [rpnf_pkg::NORM_W-1:0] o_norm_out,
    input wire logic                            o_lost_flag,
    input wire logic                            o_safe_flag,
    input wire logic [rpnf_pkg::PW_W-1:0]       o_latched_pulse
);

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_norm_out) && $stable(o_lost_flag) &&
            $stable(o_safe_flag) && $stable(o_latched_pulse))
        else $error("result changed while stalled");

    // an accepted tick keeps the block busy in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accepting a tick");

    a_lost_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_lost_flag |-> o_norm_out == '0 && !o_safe_flag)
        else $error("lost signal with nonzero command or safe flag");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_norm_out >= -16'sd16384 && o_norm_out <= 16'sd16384)
        else $error("command outside full scale");

    // the command is only released once safe start is unlocked
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_norm_out != '0 |-> o_safe_flag)
        else $error("nonzero command without safe flag");

endmodule

bind rc_pulse_normalizer_failsafe rpnf_checker u_rpnf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_norm_out     (o_norm_out),
    .o_lost_flag    (o_lost_flag),
    .o_safe_flag    (o_safe_flag),
    .o_latched_pulse(o_latched_pulse)
);

`default_nettype wire
